// ===== rtl/rowf_pkg.sv =====
package rowf_pkg;

  localparam int MaxWindow  = 7;
  localparam int MaxCols    = 1024;
  localparam int PixelBits  = 8;
  localparam int StoredRows = 10;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int RowsW    = 16;

  localparam logic [CfgIdxW-1:0] CFG_WINDOW_HALF = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RANK_MODE   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_COLS  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_ROWS  = 2'd3;

  localparam logic [1:0] MODE_MIN    = 2'd0;
  localparam logic [1:0] MODE_MEDIAN = 2'd1;

  localparam logic OP_PIXEL = 1'b0;

  typedef struct packed {
    logic       op;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       row_last;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic ld_item;
    logic mul_w;
    logic mul_r;
    logic mod_step;
    logic mem_wr;
    logic win_init;
    logic win_rd;
    logic bit_dec;
    logic out_load;
  } rowf_cmd_t;

  typedef struct packed {
    logic is_pixel;
    logic win_ready;
    logic mod_last;
    logic win_last;
    logic bit_last;
    logic out_busy;
  } rowf_sts_t;

endpackage

// ===== rtl/rank_order_window_filter.sv =====
// Channel   Dir  Handshake            Beat
// in        in   in_valid/in_ready    in_item_t  (op, pixel_in)
// out       out  out_valid/out_ready  out_item_t (pixel_out, row_last, frame_last)
// cfg       in   cfg_we               cfg_index, cfg_data (write only)
//
// One beat at a time. A drain beat that frees no result passes only the readiness
// check; a pixel beat goes first through the address product, three steps of store
// address reduction and the store write.
// A result then takes the address product, reduction, walk set-up, one bit of the
// ranked value per pass over the n = (2h+1)^2 window cells through the single store
// read port, and the hand-off to the output register.
// Reset is synchronous; the line store is not cleared.
// A stalled result holds in the output register; the next beat is taken
// meanwhile and waits only if it produces a result of its own.
module rank_order_window_filter
  import rowf_pkg::*;
#(
  parameter int MAX_WINDOW  = MaxWindow,
  parameter int MAX_COLS    = MaxCols,
  parameter int PIXEL_BITS  = PixelBits,
  parameter int STORED_ROWS = StoredRows
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data
);

  // command and status between sequencer and datapath
  rowf_cmd_t cmd;
  rowf_sts_t sts;

  // sequencer: write path, readiness check, window passes, result hand-off
  rowf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: registers, counters, line store, rank selection, result register
  rowf_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .MAX_COLS    (MAX_COLS),
    .PIXEL_BITS  (PIXEL_BITS),
    .STORED_ROWS (STORED_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/rowf_ctrl.sv =====
module rowf_ctrl
  import rowf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  rowf_sts_t sts,
  output rowf_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MULW = 4'd1;
  localparam logic [3:0] S_MODW = 4'd2;
  localparam logic [3:0] S_WR   = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_MULR = 4'd5;
  localparam logic [3:0] S_MODR = 4'd6;
  localparam logic [3:0] S_WINI = 4'd7;
  localparam logic [3:0] S_PASS = 4'd8;
  localparam logic [3:0] S_DRN  = 4'd9;
  localparam logic [3:0] S_BIT  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_next  = sts.is_pixel ? S_MULW : S_CHK;
        end
      end
      S_MULW: begin
        cmd.mul_w  = 1'b1;
        state_next = S_MODW;
      end
      S_MODW: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_next = S_WR;
      end
      S_WR: begin
        cmd.mem_wr = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        state_next = sts.win_ready ? S_MULR : S_IDLE;
      end
      S_MULR: begin
        cmd.mul_r  = 1'b1;
        state_next = S_MODR;
      end
      S_MODR: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_next = S_WINI;
      end
      S_WINI: begin
        cmd.win_init = 1'b1;
        state_next   = S_PASS;
      end
      S_PASS: begin
        cmd.win_rd = 1'b1;
        if (sts.win_last) state_next = S_DRN;
      end
      S_DRN: begin
        state_next = S_BIT;
      end
      S_BIT: begin
        cmd.bit_dec = 1'b1;
        state_next  = sts.bit_last ? S_OUT : S_PASS;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/rowf_dp.sv =====
module rowf_dp
  import rowf_pkg::*;
#(
  parameter int MAX_WINDOW  = MaxWindow,
  parameter int MAX_COLS    = MaxCols,
  parameter int PIXEL_BITS  = PixelBits,
  parameter int STORED_ROWS = StoredRows
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  in_item_t            in_data,
  input  rowf_cmd_t           cmd,
  output rowf_sts_t           sts,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data
);

  localparam int     Depth  = STORED_ROWS * MAX_COLS;
  localparam int     AW     = $clog2(Depth);
  localparam int     CW     = $clog2(MAX_COLS + 1);
  localparam int     ColW   = $clog2(MAX_COLS);
  localparam int     PW     = RowsW + CW + 1;
  localparam int     QW     = PW - AW + 1;
  localparam int     RecipW = PW - AW + 1;
  localparam longint Recip  = (longint'(1) << PW) / longint'(Depth);
  localparam int     MsW    = 2;
  localparam int     HL     = (MAX_WINDOW - 1) / 2;
  localparam int     NMax   = (2 * HL + 1) * (2 * HL + 1);
  localparam int     CntW   = $clog2(NMax + 1);
  localparam int     PBW    = $clog2(PIXEL_BITS);

  // configuration
  logic [1:0]       window_half;
  logic [1:0]       rank_mode;
  logic [10:0]      frame_cols;
  logic [RowsW-1:0] frame_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_half <= 2'd1;
      rank_mode   <= MODE_MEDIAN;
      frame_cols  <= 11'd640;
      frame_rows  <= 16'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_HALF: window_half <= cfg_data[1:0];
        CFG_RANK_MODE:   rank_mode   <= cfg_data[1:0];
        CFG_FRAME_COLS:  frame_cols  <= cfg_data[10:0];
        CFG_FRAME_ROWS:  frame_rows  <= cfg_data[RowsW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [2:0]       h;
  logic [3:0]       side;
  logic [CW-1:0]    cols;
  logic [RowsW-1:0] rows;
  logic [CntW-1:0]  ncell;
  logic [CntW-1:0]  sel;

  always_comb begin
    h    = (3'(window_half) < 3'(HL)) ? 3'(window_half) : 3'(HL);
    side = {h, 1'b1};
    if (32'(frame_cols) < 32'(side)) cols = CW'(side);
    else if (32'(frame_cols) > 32'(MAX_COLS)) cols = CW'(MAX_COLS);
    else cols = CW'(frame_cols);
    rows  = (frame_rows < RowsW'(side)) ? RowsW'(side) : frame_rows;
    ncell = CntW'(8'(side) * 8'(side));
    case (rank_mode)
      MODE_MIN:    sel = '0;
      MODE_MEDIAN: sel = ncell >> 1;
      default:     sel = ncell - 1'b1;
    endcase
  end

  // position counters
  logic [RowsW-1:0] in_row, out_row;
  logic [ColW-1:0]  in_col, out_col;
  logic             complete;

  logic [RowsW-1:0] r_hi, cr;
  logic [CW-1:0]    c_hi, cc;
  logic             win_ready;

  always_comb begin
    r_hi = rows - 1'b1 - RowsW'(h);
    c_hi = cols - 1'b1 - CW'(h);
    if (out_row < RowsW'(h)) cr = RowsW'(h);
    else if (out_row > r_hi) cr = r_hi;
    else cr = out_row;
    if (CW'(out_col) < CW'(h)) cc = CW'(h);
    else if (CW'(out_col) > c_hi) cc = c_hi;
    else cc = CW'(out_col);
    win_ready = complete
             || ((RowsW+1)'(in_row) > (RowsW+1)'(cr) + (RowsW+1)'(h))
             || (((RowsW+1)'(in_row) == (RowsW+1)'(cr) + (RowsW+1)'(h))
                 && ((CW+1)'(in_col) > (CW+1)'(cc) + (CW+1)'(h)));
  end

  logic [PIXEL_BITS-1:0] pix_q;

  // address reduction modulo the store depth: reciprocal estimate of the quotient,
  // subtract its multiple, then one compare and subtract to fix the estimate
  logic [PW-1:0]        rem;
  logic [MsW-1:0]       ms;
  logic [QW-1:0]        quot;
  logic [PW+RecipW-1:0] rprod;
  logic [PW-1:0]        qprod;

  always_comb begin
    rprod = (PW+RecipW)'(rem) * (PW+RecipW)'(Recip);
    qprod = PW'(quot) * PW'(Depth);
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) pix_q <= PIXEL_BITS'(in_data.pixel_in);
    if (cmd.mul_w) begin
      rem <= PW'(in_row) * PW'(cols) + PW'(in_col);
      ms  <= MsW'(2);
    end else if (cmd.mul_r) begin
      rem <= PW'(cr - RowsW'(h)) * PW'(cols) + PW'(cc - CW'(h));
      ms  <= MsW'(2);
    end else if (cmd.mod_step) begin
      if (ms == MsW'(2)) quot <= QW'(rprod >> PW);
      else if (ms == MsW'(1)) rem <= rem - qprod;
      else if (rem >= PW'(Depth)) rem <= rem - PW'(Depth);
      if (ms != '0) ms <= ms - 1'b1;
    end
  end

  // line store
  logic [PIXEL_BITS-1:0] mem [Depth];
  logic [PIXEL_BITS-1:0] rd_data;
  logic [AW-1:0]         addr;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[AW'(rem)] <= pix_q;
    if (cmd.win_rd) rd_data <= mem[addr];
  end

  // window walk and bitwise rank selection
  logic [AW-1:0]         start_addr, row_base;
  logic [3:0]            wi, wj;
  logic [CntW-1:0]       cnt, kreg;
  logic [PIXEL_BITS-1:0] prefix;
  logic [PBW-1:0]        bidx;
  logic                  rd_valid;
  logic [AW:0]           nb_sum, na_sum;
  logic [AW-1:0]         nb, na;
  logic [PIXEL_BITS-1:0] hi_diff;
  logic                  match;

  always_comb begin
    nb_sum  = (AW+1)'(row_base) + (AW+1)'(cols);
    nb      = (nb_sum >= (AW+1)'(Depth)) ? AW'(nb_sum - (AW+1)'(Depth)) : AW'(nb_sum);
    na_sum  = (AW+1)'(addr) + 1'b1;
    na      = (na_sum >= (AW+1)'(Depth)) ? AW'(na_sum - (AW+1)'(Depth)) : AW'(na_sum);
    hi_diff = ((rd_data ^ prefix) >> bidx) >> 1;
    match   = (hi_diff == '0) && !rd_data[bidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.win_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_init) begin
      start_addr <= AW'(rem);
      row_base   <= AW'(rem);
      addr       <= AW'(rem);
      wi         <= '0;
      wj         <= '0;
      cnt        <= '0;
      kreg       <= sel;
      prefix     <= '0;
      bidx       <= PBW'(PIXEL_BITS - 1);
    end else if (cmd.bit_dec) begin
      if (kreg >= cnt) begin
        prefix[bidx] <= 1'b1;
        kreg         <= kreg - cnt;
      end
      cnt      <= '0;
      bidx     <= bidx - 1'b1;
      row_base <= start_addr;
      addr     <= start_addr;
      wi       <= '0;
      wj       <= '0;
    end else begin
      if (cmd.win_rd) begin
        if (wj == side - 1'b1) begin
          wj       <= '0;
          wi       <= wi + 1'b1;
          row_base <= nb;
          addr     <= nb;
        end else begin
          wj   <= wj + 1'b1;
          addr <= na;
        end
      end
      if (rd_valid && match) cnt <= cnt + 1'b1;
    end
  end

  // counters and result register
  logic rlast, flast;

  always_comb begin
    rlast = (32'(out_col) + 1) >= 32'(cols);
    flast = rlast && ((32'(out_row) + 1) >= 32'(rows));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row    <= '0;
      in_col    <= '0;
      out_row   <= '0;
      out_col   <= '0;
      complete  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.mem_wr) begin
        if ((32'(in_col) + 1) >= 32'(cols)) begin
          in_col <= '0;
          if ((32'(in_row) + 1) >= 32'(rows)) begin
            in_row   <= '0;
            complete <= 1'b1;
          end else begin
            in_row <= in_row + 1'b1;
          end
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        if (flast) begin
          out_row  <= '0;
          out_col  <= '0;
          in_row   <= '0;
          in_col   <= '0;
          complete <= 1'b0;
        end else if (rlast) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.pixel_out  <= 8'(prefix);
      out_data.row_last   <= rlast;
      out_data.frame_last <= flast;
    end
  end

  always_comb begin
    sts.is_pixel  = (in_data.op == OP_PIXEL) && !complete;
    sts.win_ready = win_ready;
    sts.mod_last  = (ms == '0);
    sts.win_last  = (wi == side - 1'b1) && (wj == side - 1'b1);
    sts.bit_last  = (bidx == '0);
    sts.out_busy  = out_valid && !out_ready;
  end

endmodule
